[src/sobie_pkg.sv]
// Shared types, widths and helpers for the sensitivity index estimator.
`default_nettype none
package sobie_pkg;

  localparam int unsigned DATA_W    = 24;
  localparam int unsigned MUL_W     = 25;
  localparam int unsigned PROD_W    = 50;
  localparam int unsigned SUM_A_W   = 40;
  localparam int unsigned SUM_ASQ_W = 60;
  localparam int unsigned SUM_W     = 62;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned OUT_W     = 21;
  localparam int unsigned DIVN_W    = 64;
  localparam int unsigned DIVD_W    = 48;
  localparam int unsigned NUM_W     = 49;
  localparam int unsigned RAT_W     = 24;

  localparam logic [0:0] REG_MODE = 1'b0;
  localparam logic [0:0] REG_MIN  = 1'b1;

  localparam logic [1:0] MODE_2002 = 2'd0;
  localparam logic [1:0] MODE_2007 = 2'd1;
  localparam logic [1:0] MODE_2010 = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FEW  = 2'd1;
  localparam logic [1:0] STATUS_ZVAR = 2'd2;

  localparam logic [DIVN_W-1:0] Q_CLAMP = DIVN_W'(64'd1 << 22);
  localparam logic signed [RAT_W-1:0] Q_ONE   = 24'sd65536;
  localparam logic signed [RAT_W-1:0] OUT_MAX = 24'sd1048575;
  localparam logic signed [RAT_W-1:0] OUT_MIN = -24'sd1048576;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_CHECK, ST_DIV_GO, ST_DIV_WAIT, ST_SQUARE, ST_VAR, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    DS_F0, DS_MSQ, DS_DY, DS_R1, DS_TN, DS_R2
  } dstep_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [RAT_W-1:0] v);
    logic signed [RAT_W-1:0] r;
    if (v > OUT_MAX) r = OUT_MAX;
    else if (v < OUT_MIN) r = OUT_MIN;
    else r = v;
    return r[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

[src/sobie_mul.sv]
// Shared signed multiplier with registered product.
`default_nettype none
module sobie_mul
  import sobie_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [MUL_W-1:0]  a,
  input  wire logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0]      p
);

  logic signed [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule
`default_nettype wire

[src/sobie_div.sv]
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
`default_nettype none
module sobie_div
  import sobie_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIVN_W-1:0] dividend,
  input  wire logic [DIVD_W-1:0] divisor,
  output div_stat_t              stat,
  output logic [DIVN_W-1:0]      quotient
);

  localparam int unsigned CNT_W = $clog2(DIVN_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVD_W-1:0] rem_r, rem_nxt;
  logic [DIVD_W-1:0] dvs_r, dvs_nxt;
  logic [DIVN_W-1:0] quo_r, quo_nxt;
  logic [DIVD_W:0]   trial;
  logic [DIVD_W:0]   diff;

  always_comb begin
    trial    = {rem_r, quo_r[DIVN_W-1]};
    diff     = trial - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      if (!diff[DIVD_W]) begin
        rem_nxt = diff[DIVD_W-1:0];
        quo_nxt = {quo_r[DIVN_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIVD_W-1:0];
        quo_nxt = {quo_r[DIVN_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIVN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule
`default_nettype wire

[src/sobol_index_estimator_core.sv]
// Top level: sample accumulation and batch-end index evaluation.
//
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_ready   | three outputs, three ok flags, last mark
//  out_    | output    | out_valid / out_ready | first_order, total_order, status
//  cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// A sample is accepted, then takes six steps, five of them through the shared 25x25 multiplier.
// A batch end runs up to six passes of the serial divider.
// Results wait in an output register; a new batch end stalls only while it is full.
// Reset is synchronous; it clears all sums and counts and leaves no clearing pass.
`default_nettype none
module sobol_index_estimator_core
  import sobie_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [0:0]               cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_wdata,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [DATA_W-1:0] in_out_a,
  input  wire logic signed [DATA_W-1:0] in_out_b,
  input  wire logic signed [DATA_W-1:0] in_out_mixed,
  input  wire logic                     in_ok_a,
  input  wire logic                     in_ok_b,
  input  wire logic                     in_ok_mixed,
  input  wire logic                     in_last_sample,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [OUT_W-1:0]       out_first_order,
  output logic signed [OUT_W-1:0]       out_total_order,
  output logic [1:0]                    out_status
);

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  function automatic logic [DIVN_W-1:0] mag_sum(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] m;
    m = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    return DIVN_W'(m);
  endfunction

  function automatic logic [DIVD_W-1:0] mag_num(input logic signed [NUM_W-1:0] v);
    logic [NUM_W-1:0] m;
    m = v[NUM_W-1] ? NUM_W'(-v) : NUM_W'(v);
    return m[DIVD_W-1:0];
  endfunction

  function automatic logic signed [RAT_W-1:0] ratio(input logic neg,
                                                    input logic [DIVN_W-1:0] q);
    logic [RAT_W-1:0] m;
    m = (q > Q_CLAMP) ? RAT_W'(Q_CLAMP) : RAT_W'(q);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  state_t state_r, state_nxt;
  dstep_t dstep_r;
  logic [2:0] step_r;

  logic [1:0]       mode_r;
  logic [CFG_W-1:0] min_r;

  logic signed [DATA_W-1:0] ya_r, yb_r, yc_r;
  logic signed [MUL_W-1:0]  dcy_r, dbc_r;
  logic en_a_r, en3_r, enbc_r, last_r;

  logic signed [SUM_A_W-1:0] sum_a_r;
  logic [SUM_ASQ_W-1:0]      sum_asq_r;
  logic signed [SUM_W-1:0]   sum_fc_r, sum_bm_r, sum_tl_r;
  logic [SUM_W-1:0]          sum_ts_r;
  logic [CNT_W-1:0]          cnt_a_r, cnt3_r, cnt_bc_r;

  logic signed [MUL_W-1:0]   f0_r;
  logic signed [DIVD_W-1:0]  f0sq_r;
  logic [DIVD_W-2:0]         msq_r;
  logic signed [DIVD_W-1:0]  dvar_r;
  logic signed [NUM_W-1:0]   num_r;
  logic signed [OUT_W-1:0]   first_r, total_r;
  logic [1:0]                status_r;

  logic                      out_valid_r;
  logic signed [OUT_W-1:0]   out_first_r, out_total_r;
  logic [1:0]                out_status_r;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic                      div_start;
  logic [DIVN_W-1:0]         div_dividend, div_q;
  logic [DIVD_W-1:0]         div_divisor;
  div_stat_t                 div_stat;

  logic in_fire, few, slot_free;
  logic signed [DIVD_W-1:0] dvar_calc;
  logic signed [RAT_W-1:0]  rq;
  logic signed [NUM_W-1:0]  tn;

  sobie_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  sobie_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_q)
  );

  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign few = (cnt_a_r == '0) || (cnt3_r == '0) || (cnt_bc_r == '0) ||
               (CFG_W'(cnt_a_r) < min_r) || (CFG_W'(cnt3_r) < min_r) ||
               (CFG_W'(cnt_bc_r) < min_r);
  assign dvar_calc = $signed({1'b0, msq_r}) - f0sq_r;
  assign rq = ratio(num_r[NUM_W-1], div_q);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_fire) state_nxt = ST_MAC;
      ST_MAC:      if (step_r == 3'd5) state_nxt = last_r ? ST_CHECK : ST_IDLE;
      ST_CHECK:    state_nxt = few ? ST_DONE : ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          unique case (dstep_r)
            DS_F0:   state_nxt = ST_SQUARE;
            DS_MSQ:  state_nxt = ST_VAR;
            DS_R2:   state_nxt = ST_DONE;
            default: state_nxt = ST_DIV_GO;
          endcase
        end
      end
      ST_SQUARE:   if (step_r == 3'd1) state_nxt = ST_DIV_GO;
      ST_VAR:      state_nxt = (dvar_calc <= 0) ? ST_DONE : ST_DIV_GO;
      ST_DONE:     if (slot_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    div_start = (state_r == ST_DIV_GO);
    mul_a     = '0;
    mul_b     = '0;
    tn        = '0;
    if (state_r == ST_MAC) begin
      unique case (step_r)
        3'd0:    begin mul_a = MUL_W'(ya_r); mul_b = MUL_W'(ya_r); end
        3'd1:    begin mul_a = dcy_r;        mul_b = MUL_W'(ya_r); end
        3'd2:    begin mul_a = MUL_W'(yb_r); mul_b = MUL_W'(yc_r); end
        3'd3:    begin mul_a = dbc_r;        mul_b = MUL_W'(yb_r); end
        3'd4:    begin mul_a = dbc_r;        mul_b = dbc_r;        end
        default: begin mul_a = '0;           mul_b = '0;           end
      endcase
    end else if (state_r == ST_SQUARE) begin
      mul_a = f0_r;
      mul_b = f0_r;
    end
    div_dividend = '0;
    div_divisor  = '0;
    unique case (dstep_r)
      DS_F0: begin
        div_dividend = mag_sum(SUM_W'(sum_a_r));
        div_divisor  = DIVD_W'(cnt_a_r);
      end
      DS_MSQ: begin
        div_dividend = DIVN_W'(sum_asq_r);
        div_divisor  = DIVD_W'(cnt_a_r);
      end
      DS_DY: begin
        div_dividend = mag_sum(sum_fc_r);
        div_divisor  = DIVD_W'(cnt3_r);
      end
      DS_TN: begin
        if (mode_r == MODE_2002) begin
          div_dividend = mag_sum(sum_bm_r);
          div_divisor  = DIVD_W'(cnt_bc_r);
        end else if (mode_r == MODE_2007) begin
          div_dividend = mag_sum(sum_tl_r);
          div_divisor  = DIVD_W'(cnt_bc_r);
        end else begin
          div_dividend = DIVN_W'(sum_ts_r);
          div_divisor  = DIVD_W'({cnt_bc_r, 1'b0});
        end
      end
      default: begin
        div_dividend = {mag_num(num_r), 16'd0};
        div_divisor  = dvar_r;
      end
    endcase
    if (mode_r == MODE_2002) begin
      tn = (sum_bm_r[SUM_W-1] ? -$signed(NUM_W'(div_q)) : $signed(NUM_W'(div_q)))
           - NUM_W'(f0sq_r);
    end else if (mode_r == MODE_2007) begin
      tn = sum_tl_r[SUM_W-1] ? -$signed(NUM_W'(div_q)) : $signed(NUM_W'(div_q));
    end else begin
      tn = $signed(NUM_W'(div_q));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dstep_r     <= DS_F0;
      step_r      <= '0;
      mode_r      <= MODE_2010;
      min_r       <= '0;
      out_valid_r <= 1'b0;
      sum_a_r     <= '0;
      sum_asq_r   <= '0;
      sum_fc_r    <= '0;
      sum_bm_r    <= '0;
      sum_tl_r    <= '0;
      sum_ts_r    <= '0;
      cnt_a_r     <= '0;
      cnt3_r      <= '0;
      cnt_bc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE: mode_r <= cfg_wdata[1:0];
          REG_MIN:  min_r  <= cfg_wdata;
          default:  min_r  <= min_r;
        endcase
      end
      if (state_r == ST_DONE && slot_free) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            step_r <= '0;
            if (in_ok_a && cnt_a_r < CNT_MAX) begin
              sum_a_r <= sum_a_r + SUM_A_W'(in_out_a);
              cnt_a_r <= cnt_a_r + 1'b1;
            end
            if (in_ok_a && in_ok_b && in_ok_mixed && cnt3_r < CNT_MAX)
              cnt3_r <= cnt3_r + 1'b1;
            if (in_ok_b && in_ok_mixed && cnt_bc_r < CNT_MAX)
              cnt_bc_r <= cnt_bc_r + 1'b1;
          end
        end
        ST_MAC: begin
          step_r <= step_r + 1'b1;
          unique case (step_r)
            3'd1:    if (en_a_r) sum_asq_r <= sum_asq_r + SUM_ASQ_W'(prod);
            3'd2:    if (en3_r)  sum_fc_r  <= sum_fc_r + SUM_W'(prod);
            3'd3:    if (enbc_r) sum_bm_r  <= sum_bm_r + SUM_W'(prod);
            3'd4:    if (enbc_r) sum_tl_r  <= sum_tl_r + SUM_W'(prod);
            3'd5:    if (enbc_r) sum_ts_r  <= sum_ts_r + SUM_W'(prod);
            default: sum_ts_r <= sum_ts_r;
          endcase
        end
        ST_CHECK: begin
          first_r  <= '0;
          total_r  <= '0;
          status_r <= STATUS_FEW;
          dstep_r  <= DS_F0;
          step_r   <= '0;
        end
        ST_DIV_WAIT: begin
          if (div_stat.done) begin
            unique case (dstep_r)
              DS_F0: begin
                f0_r   <= sum_a_r[SUM_A_W-1] ? -$signed(MUL_W'(div_q)) :
                                                $signed(MUL_W'(div_q));
                step_r <= '0;
              end
              DS_MSQ: msq_r <= div_q[DIVD_W-2:0];
              DS_DY: begin
                num_r   <= sum_fc_r[SUM_W-1] ? -$signed(NUM_W'(div_q)) :
                                                $signed(NUM_W'(div_q));
                dstep_r <= DS_R1;
              end
              DS_R1: begin
                first_r <= sat_out(rq);
                dstep_r <= DS_TN;
              end
              DS_TN: begin
                num_r   <= tn;
                dstep_r <= DS_R2;
              end
              default: begin
                total_r  <= (mode_r == MODE_2002) ? sat_out(Q_ONE - rq) : sat_out(rq);
                status_r <= STATUS_OK;
              end
            endcase
          end
        end
        ST_SQUARE: begin
          step_r <= step_r + 1'b1;
          if (step_r == 3'd1) begin
            f0sq_r  <= DIVD_W'(prod);
            dstep_r <= DS_MSQ;
          end
        end
        ST_VAR: begin
          dvar_r  <= dvar_calc;
          dstep_r <= DS_DY;
          if (dvar_calc <= 0) begin
            first_r  <= '0;
            total_r  <= '0;
            status_r <= STATUS_ZVAR;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            sum_a_r     <= '0;
            sum_asq_r   <= '0;
            sum_fc_r    <= '0;
            sum_bm_r    <= '0;
            sum_tl_r    <= '0;
            sum_ts_r    <= '0;
            cnt_a_r     <= '0;
            cnt3_r      <= '0;
            cnt_bc_r    <= '0;
          end
        end
        default: step_r <= step_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ya_r   <= in_out_a;
      yb_r   <= in_out_b;
      yc_r   <= in_out_mixed;
      dcy_r  <= MUL_W'(in_out_mixed) - MUL_W'(in_out_b);
      dbc_r  <= MUL_W'(in_out_b) - MUL_W'(in_out_mixed);
      last_r <= in_last_sample;
      en_a_r <= in_ok_a && (cnt_a_r < CNT_MAX);
      en3_r  <= in_ok_a && in_ok_b && in_ok_mixed && (cnt3_r < CNT_MAX);
      enbc_r <= in_ok_b && in_ok_mixed && (cnt_bc_r < CNT_MAX);
    end
    if (state_r == ST_DONE && slot_free) begin
      out_first_r  <= first_r;
      out_total_r  <= total_r;
      out_status_r <= status_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_first_order = out_first_r;
  assign out_total_order = out_total_r;
  assign out_status      = out_status_r;

endmodule
`default_nettype wire

[test/sobol_index_estimator_core_tb.sv]
// Self-checking testbench for the sensitivity index estimator core: directed and random batches with checking.
module sobol_index_estimator_core_tb;
  import sobie_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] ya;
    logic signed [DATA_W-1:0] yb;
    logic signed [DATA_W-1:0] yc;
    logic ok_a;
    logic ok_b;
    logic ok_c;
    logic last;
  } sample_t;

  typedef struct {
    logic signed [OUT_W-1:0] first_order;
    logic signed [OUT_W-1:0] total_order;
    logic [1:0] status;
  } index_t;

  localparam int unsigned SAMPLE_CAP = 4096;
  localparam int unsigned SETTLE = 20;
  localparam int unsigned STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_MODE;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DATA_W-1:0] in_out_a = '0;
  logic signed [DATA_W-1:0] in_out_b = '0;
  logic signed [DATA_W-1:0] in_out_mixed = '0;
  logic in_ok_a = 1'b0;
  logic in_ok_b = 1'b0;
  logic in_ok_mixed = 1'b0;
  logic in_last_sample = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_first_order;
  logic signed [OUT_W-1:0] out_total_order;
  logic [1:0] out_status;

  sobol_index_estimator_core dut (.*);

  always #5 clk = ~clk;

  sample_t pending_samples[$];
  index_t expected_indices[$];
  sample_t driven;
  bit no_idle = 1'b0;
  int errors = 0;
  int samples_sent = 0;
  int batches_checked = 0;
  int quiet_cycles = 0;
  int status_seen[3] = '{0, 0, 0};

  logic [1:0] est_mode = MODE_2010;
  int unsigned min_count = 0;
  longint acc_a, acc_asq, acc_cross, acc_bc, acc_lin, acc_sq;
  int unsigned n_a, n_all, n_bc;

  function automatic longint ratio_q16(input longint num, input longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag << 16) / den;
    if (q > (64'd1 << 22)) q = 64'd1 << 22;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp_q416(input longint v);
    if (v > 1048575) return 1048575;
    if (v < -1048576) return -1048576;
    return v;
  endfunction

  function automatic void clear_sums();
    acc_a = 0; acc_asq = 0; acc_cross = 0; acc_bc = 0; acc_lin = 0; acc_sq = 0;
    n_a = 0; n_all = 0; n_bc = 0;
  endfunction

  function automatic void accumulate_sample(input sample_t s);
    longint a, b, c, d, f0, f0sq, dvar, m;
    longint first_q, total_q;
    index_t r;
    a = s.ya; b = s.yb; c = s.yc;
    if (s.ok_a && n_a < SAMPLE_CAP) begin
      acc_a += a; acc_asq += a * a; n_a++;
    end
    if (s.ok_a && s.ok_b && s.ok_c && n_all < SAMPLE_CAP) begin
      acc_cross += (c - b) * a; n_all++;
    end
    if (s.ok_b && s.ok_c && n_bc < SAMPLE_CAP) begin
      d = b - c;
      acc_bc += b * c; acc_lin += d * b; acc_sq += d * d; n_bc++;
    end
    if (!s.last) return;
    first_q = 0; total_q = 0;
    if (n_a == 0 || n_all == 0 || n_bc == 0 ||
        n_a < min_count || n_all < min_count || n_bc < min_count) begin
      r.status = STATUS_FEW;
    end else begin
      f0 = acc_a / longint'(n_a);
      f0sq = f0 * f0;
      dvar = acc_asq / longint'(n_a) - f0sq;
      if (dvar <= 0) begin
        r.status = STATUS_ZVAR;
      end else begin
        r.status = STATUS_OK;
        first_q = clamp_q416(ratio_q16(acc_cross / longint'(n_all), dvar));
        if (est_mode == MODE_2002) begin
          m = acc_bc / longint'(n_bc);
          total_q = clamp_q416(65536 - ratio_q16(m - f0sq, dvar));
        end else if (est_mode == MODE_2007) begin
          total_q = clamp_q416(ratio_q16(acc_lin / longint'(n_bc), dvar));
        end else begin
          total_q = clamp_q416(ratio_q16(acc_sq / (2 * longint'(n_bc)), dvar));
        end
      end
    end
    r.first_order = first_q[OUT_W-1:0];
    r.total_order = total_q[OUT_W-1:0];
    expected_indices.push_back(r);
    clear_sums();
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      accumulate_sample(driven);
      samples_sent++;
    end
    if (rst_n && (!in_valid || in_ready) && pending_samples.size() != 0 &&
        (no_idle || $urandom_range(99) >= 19)) begin
      driven = pending_samples.pop_front();
      in_valid <= 1'b1;
      in_out_a <= driven.ya;
      in_out_b <= driven.yb;
      in_out_mixed <= driven.yc;
      in_ok_a <= driven.ok_a;
      in_ok_b <= driven.ok_b;
      in_ok_mixed <= driven.ok_c;
      in_last_sample <= driven.last;
    end else if (in_ready) begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    index_t want;
    if (out_valid && out_ready) begin
      if (expected_indices.size() == 0) begin
        report_mismatch("result with nothing expected, status", out_status, -1);
      end else begin
        want = expected_indices.pop_front();
        if (out_first_order !== want.first_order)
          report_mismatch("first_order", out_first_order, want.first_order);
        if (out_total_order !== want.total_order)
          report_mismatch("total_order", out_total_order, want.total_order);
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_status < 3) status_seen[out_status]++;
        batches_checked++;
      end
    end
    out_ready <= no_idle || $urandom_range(99) >= 19;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n ||
        (pending_samples.size() == 0 && expected_indices.size() == 0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_indices.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_sample(input int a, input int b, input int c,
                             input bit oka, input bit okb, input bit okc, input bit last);
    sample_t s;
    s.ya = a[DATA_W-1:0]; s.yb = b[DATA_W-1:0]; s.yc = c[DATA_W-1:0];
    s.ok_a = oka; s.ok_b = okb; s.ok_c = okc; s.last = last;
    pending_samples.push_back(s);
  endtask

  function automatic int near(input int center, input int amp);
    return center + int'($urandom_range(2 * amp)) - amp;
  endfunction

  task automatic push_batch();
    int n, pick, base, amp, a, b, c;
    n = $urandom_range(1, 10);
    pick = $urandom_range(99);
    base = (int'($urandom_range(4095)) - 2048) <<< 8;
    amp = 1 << $urandom_range(2, 20);
    for (int i = 0; i < n; i++) begin
      if (pick < 65) begin
        a = near(base, amp);
        b = near(base, amp);
        c = ($urandom_range(1)) ? near(a, amp / 4 + 1) : near(b, amp / 4 + 1);
        push_sample(a, b, c, $urandom_range(9) != 0, $urandom_range(9) != 0,
                    $urandom_range(9) != 0, i == n - 1);
      end else if (pick < 85) begin
        push_sample($urandom, $urandom, $urandom, $urandom_range(1), $urandom_range(1),
                    $urandom_range(1), i == n - 1);
      end else begin
        push_sample(base, near(base, amp), $urandom, $urandom_range(3) == 0,
                    $urandom_range(1), $urandom_range(1), i == n - 1);
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_indices.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MODE) est_mode = value[1:0];
    else min_count = value[CFG_W-1:0];
    @(posedge clk);
  endtask

  task automatic random_phase(input logic [1:0] mode, input int unsigned minv,
                              input int items);
    write_reg(REG_MODE, mode);
    write_reg(REG_MIN, minv);
    while (pending_samples.size() < items) push_batch();
    wait_drained();
  endtask

  initial begin
    clear_sums();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_sample(8388607, -8388608, 8388607, 1, 1, 1, 0);
    push_sample(-8388608, 8388607, -8388608, 1, 1, 1, 0);
    push_sample(0, -1, 1, 1, 1, 1, 1);
    push_sample(4096, 100, 200, 1, 1, 1, 0);
    push_sample(4096, -300, 50, 1, 1, 1, 1);
    push_sample(5, 6, 7, 0, 1, 1, 1);
    push_sample(5, 6, 7, 1, 0, 1, 1);
    push_sample(-77, 6, 7, 1, 1, 1, 1);
    push_sample(1000, 2000, 3000, 1, 1, 1, 0);
    push_sample(9000, -2000, 8000, 1, 1, 1, 0);
    push_sample(-4000, 2500, 2600, 1, 1, 1, 1);
    push_sample(10, 0, 0, 1, 1, 0, 0);
    push_sample(20, 0, 0, 1, 1, 0, 1);
    wait_drained();
    write_reg(REG_MODE, MODE_2002);
    push_sample(3000, 40, 50, 1, 1, 1, 0);
    push_sample(-7000, 8388607, 8388607, 1, 1, 1, 1);
    wait_drained();
    write_reg(REG_MODE, MODE_2007);
    push_sample(3000, 8388607, -8388608, 1, 1, 1, 0);
    push_sample(-7000, -8388608, 8388607, 1, 1, 1, 1);
    wait_drained();
    write_reg(REG_MODE, 3);
    push_sample(3000, 8388607, -8388608, 1, 1, 1, 0);
    push_sample(-7000, 12, 13, 1, 1, 1, 1);
    wait_drained();

    random_phase(MODE_2002, 0, 100);
    random_phase(MODE_2007, 3, 100);
    random_phase(3, 1, 80);
    random_phase(MODE_2010, 0, 100);
    random_phase(MODE_2002, 4096, 50);

    no_idle = 1'b1;
    random_phase(MODE_2007, 0, 100);
    no_idle = 1'b0;
    write_reg(REG_MIN, 8191);
    random_phase(MODE_2010, 0, 60);

    $display("covered %0d samples in %0d checked batches (ok %0d, few %0d, zero var %0d)",
             samples_sent, batches_checked, status_seen[0], status_seen[1], status_seen[2]);
    $display("all estimator modes, minimum counts 0 to 4096 and a stretch with no idling");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
